### rtl/assert_macros.svh
// Assertion helpers. Both expect aclk and aresetn in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while in reset.
`define ASSERT_IMPLY(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication, masked while in reset.
`define ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

### rtl/ssrac_pkg.sv
package ssrac_pkg;

    localparam int READ_REGS_DEF = 8;
    localparam int WRITE_REGS    = 4;
    localparam int CMD_IDX_W     = 7;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'd1;

    localparam logic [7:0]  CRC_POLY_RST = 8'h07;
    localparam logic [15:0] TIMEOUT_RST  = 16'd5;

    typedef enum logic [1:0] {
        OP_RX_BYTE = 2'd0,
        OP_TICK    = 2'd1,
        OP_LOAD    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_DATA_LO  = 5'b00010,
        PH_DATA_HI  = 5'b00100,
        PH_WR_CRC   = 5'b01000,
        PH_RD_TRAIL = 5'b10000
    } phase_t;

    // What the second stage does with an item.
    typedef enum logic [2:0] {
        ACT_HOLD    = 3'd0,
        ACT_CMD     = 3'd1,
        ACT_DATA_LO = 3'd2,
        ACT_DATA_HI = 3'd3,
        ACT_WR_CRC  = 3'd4,
        ACT_CLEAR   = 3'd5
    } act_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  rx_byte;
        logic [2:0]  load_index;
        logic [15:0] load_value;
    } spi_in_t;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        write_valid;
        logic [1:0]  write_index;
        logic [15:0] write_value;
        logic        write_crc_ok;
    } spi_out_t;

    typedef struct packed {
        act_t       act;
        logic       is_write;
        logic       rd_ok;
        logic       wr_ok;
        logic [1:0] wr_index;
        logic [7:0] rx_byte;
    } s1_t;

    // One byte through an MSB-first CRC-8.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### rtl/ssrac_ram.sv
module ssrac_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/ssrac_frame_ctrl.sv
module ssrac_frame_ctrl #(
    parameter int READ_REGS = ssrac_pkg::READ_REGS_DEF,
    localparam int AW = (READ_REGS > 1) ? $clog2(READ_REGS) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic              advance,
    input  ssrac_pkg::spi_in_t in_item,
    input  logic [15:0]       timeout_ticks,
    output logic              s1_valid,
    output ssrac_pkg::s1_t    s1_item,
    output logic              ram_rd_en,
    output logic [AW-1:0]     ram_rd_addr,
    output logic              ram_wr_en,
    output logic [AW-1:0]     ram_wr_addr,
    output logic [15:0]       ram_wr_data
);
    import ssrac_pkg::*;

    phase_t               phase_reg, phase_next;
    logic                 is_write_reg, is_write_next;
    logic [CMD_IDX_W-1:0] cmd_idx_reg, cmd_idx_next;
    logic [15:0]          tmo_reg, tmo_next;
    logic [READ_REGS-1:0] loaded_reg, loaded_next;
    logic                 s1_valid_reg, s1_valid_next;
    s1_t                  s1_reg, s1_next;

    logic [CMD_IDX_W-1:0] idx;
    logic [CMD_IDX_W-1:0] ld_idx;
    logic                 idx_in_range;
    logic                 ld_in_range;

    // Index of the current frame: the command byte itself or the stored one.
    assign idx          = (phase_reg == PH_IDLE) ? in_item.rx_byte[CMD_IDX_W-1:0] : cmd_idx_reg;
    assign ld_idx       = CMD_IDX_W'(in_item.load_index);
    assign idx_in_range = ({1'b0, idx} < 8'(READ_REGS));
    assign ld_in_range  = ({1'b0, ld_idx} < 8'(READ_REGS));

    assign ram_rd_addr = idx[AW-1:0];
    assign ram_wr_addr = ld_idx[AW-1:0];
    assign ram_wr_data = in_item.load_value;

    always_comb begin
        phase_next    = phase_reg;
        is_write_next = is_write_reg;
        cmd_idx_next  = cmd_idx_reg;
        tmo_next      = tmo_reg;
        loaded_next   = loaded_reg;
        ram_rd_en     = 1'b0;
        ram_wr_en     = 1'b0;

        s1_next.act      = ACT_HOLD;
        s1_next.is_write = is_write_reg;
        s1_next.rd_ok    = idx_in_range && loaded_reg[ram_rd_addr];
        s1_next.wr_ok    = ({1'b0, idx} < 8'(WRITE_REGS));
        s1_next.wr_index = idx[1:0];
        s1_next.rx_byte  = in_item.rx_byte;

        case (in_item.op)
            OP_RX_BYTE: begin
                ram_rd_en = accept;
                case (phase_reg)
                    PH_IDLE: begin
                        s1_next.act      = ACT_CMD;
                        s1_next.is_write = in_item.rx_byte[7];
                        is_write_next    = in_item.rx_byte[7];
                        cmd_idx_next     = in_item.rx_byte[CMD_IDX_W-1:0];
                        tmo_next         = timeout_ticks;
                        phase_next       = PH_DATA_LO;
                    end
                    PH_DATA_LO: begin
                        s1_next.act = ACT_DATA_LO;
                        phase_next  = PH_DATA_HI;
                    end
                    PH_DATA_HI: begin
                        s1_next.act = ACT_DATA_HI;
                        phase_next  = is_write_reg ? PH_WR_CRC : PH_RD_TRAIL;
                    end
                    PH_WR_CRC: begin
                        s1_next.act = ACT_WR_CRC;
                        phase_next  = PH_IDLE;
                    end
                    default: begin
                        s1_next.act = ACT_CLEAR;
                        phase_next  = PH_IDLE;
                    end
                endcase
            end
            OP_TICK: begin
                if (tmo_reg != 16'd0) begin
                    tmo_next = tmo_reg - 16'd1;
                    if (tmo_reg == 16'd1) begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            OP_LOAD: begin
                if (ld_in_range) begin
                    ram_wr_en = accept;
                    loaded_next[ram_wr_addr] = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            is_write_reg <= 1'b0;
            cmd_idx_reg  <= '0;
            tmo_reg      <= '0;
            loaded_reg   <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            if (accept) begin
                phase_reg    <= phase_next;
                is_write_reg <= is_write_next;
                cmd_idx_reg  <= cmd_idx_next;
                tmo_reg      <= tmo_next;
                loaded_reg   <= loaded_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= s1_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_reg;

endmodule

### rtl/ssrac_datapath.sv
module ssrac_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  ssrac_pkg::s1_t      s1_item,
    input  logic [15:0]         ram_rd_data,
    input  logic [7:0]          crc_poly,
    input  logic                m_ready,
    output logic                m_valid,
    output ssrac_pkg::spi_out_t m_data
);
    import ssrac_pkg::*;

    logic [7:0]  tx_reg, tx_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] dword_reg, dword_next;
    logic        m_valid_reg, m_valid_next;
    spi_out_t    m_data_reg, m_data_next;

    logic [15:0] rd_val;
    logic        rd_path;
    logic [7:0]  crc_base;
    logic [7:0]  crc_byte;
    logic [7:0]  crc_calc;

    assign rd_val   = s1_item.rd_ok ? ram_rd_data : 16'd0;
    // Read frames feed the CRC with the bytes sent, write frames with those received.
    assign rd_path  = !s1_item.is_write &&
                      ((s1_item.act == ACT_CMD) || (s1_item.act == ACT_DATA_LO));
    assign crc_base = (s1_item.act == ACT_CMD) ? 8'd0 : crc_reg;
    assign crc_byte = !rd_path ? s1_item.rx_byte :
                      (s1_item.act == ACT_CMD) ? rd_val[7:0] : rd_val[15:8];
    assign crc_calc = crc8_byte(crc_base, crc_byte, crc_poly);

    always_comb begin
        tx_next     = tx_reg;
        crc_next    = crc_reg;
        dword_next  = dword_reg;
        m_data_next = '0;

        case (s1_item.act)
            ACT_HOLD: begin
            end
            ACT_CMD: begin
                tx_next  = s1_item.is_write ? 8'd0 : rd_val[7:0];
                crc_next = crc_calc;
            end
            ACT_DATA_LO: begin
                tx_next  = s1_item.is_write ? 8'd0 : rd_val[15:8];
                crc_next = crc_calc;
                if (s1_item.is_write) begin
                    dword_next = {8'd0, s1_item.rx_byte};
                end
            end
            ACT_DATA_HI: begin
                if (s1_item.is_write) begin
                    tx_next    = 8'd0;
                    crc_next   = crc_calc;
                    dword_next = {s1_item.rx_byte, dword_reg[7:0]};
                end else begin
                    tx_next = crc_reg;
                end
            end
            ACT_WR_CRC: begin
                tx_next  = 8'd0;
                crc_next = crc_calc;
                if (s1_item.wr_ok) begin
                    m_data_next.write_valid  = 1'b1;
                    m_data_next.write_index  = s1_item.wr_index;
                    m_data_next.write_value  = dword_reg;
                    m_data_next.write_crc_ok = (crc_calc == 8'd0);
                end
            end
            default: begin
                tx_next = 8'd0;
            end
        endcase

        m_data_next.tx_byte = tx_next;

        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_reg      <= '0;
            crc_reg     <= '0;
            dword_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (advance) begin
                tx_reg    <= tx_next;
                crc_reg   <= crc_next;
                dword_reg <= dword_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/spi_slave_register_access_crc8_unit.sv
// Slave end of a four-byte SPI register protocol with a CRC-8 check. Every input transfer
// (a received byte, a timer tick or a read-register load) yields exactly one output
// transfer: tx_byte is the byte to shift out on the next SPI byte, and a finished write
// frame to an index below WRITE_REGS shows up once with write_valid, its index, its value
// and write_crc_ok. Rate: one transfer per clock sustained while m_ready is high. Stage
// one runs the frame phase, the timeout counter and the RAM access; stage two runs the
// CRC, the data word and the transmit byte into the output register. The block keeps
// taking input while a result waits at the output, up to one item held between the
// stages. Read-register entries never loaded read as zero. crc_polynomial (index 0, reset
// 0x07) and timeout_ticks (index 1, reset 5, 0 disables) are to be written by the user
// only while the block is idle; the block itself does not enforce this.
module spi_slave_register_access_crc8_unit #(
    parameter int READ_REGS = ssrac_pkg::READ_REGS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ssrac_pkg::spi_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ssrac_pkg::spi_out_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [ssrac_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ssrac_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import ssrac_pkg::*;

    localparam int AW = (READ_REGS > 1) ? $clog2(READ_REGS) : 1;

    logic [7:0]  crc_poly_reg;
    logic [15:0] timeout_reg;

    logic          accept;
    logic          advance;
    logic          s1_valid;
    s1_t           s1_item;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [15:0]   ram_wr_data;
    logic [15:0]   ram_rd_data;

    // Stage two moves when stage one holds an item and the output register is free or draining this cycle.
    assign advance = s1_valid && (!m_valid || m_ready);
    assign s_ready = !s1_valid || !m_valid || m_ready;
    assign accept  = s_valid && s_ready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_poly_reg <= CRC_POLY_RST;
            timeout_reg  <= TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CRC_POLY: crc_poly_reg <= cfg_wr_data[7:0];
                CFG_TIMEOUT:  timeout_reg  <= cfg_wr_data[15:0];
                default: begin
                end
            endcase
        end
    end

    ssrac_frame_ctrl #(
        .READ_REGS (READ_REGS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .advance       (advance),
        .in_item       (s_data),
        .timeout_ticks (timeout_reg),
        .s1_valid      (s1_valid),
        .s1_item       (s1_item),
        .ram_rd_en     (ram_rd_en),
        .ram_rd_addr   (ram_rd_addr),
        .ram_wr_en     (ram_wr_en),
        .ram_wr_addr   (ram_wr_addr),
        .ram_wr_data   (ram_wr_data)
    );

    // Read-register store; the read data holds until the next read.
    ssrac_ram #(
        .WIDTH (16),
        .DEPTH (READ_REGS)
    ) u_read_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    ssrac_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .s1_item     (s1_item),
        .ram_rd_data (ram_rd_data),
        .crc_poly    (crc_poly_reg),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_data      (m_data)
    );

endmodule

### rtl/ssrac_checker.sv
`include "assert_macros.svh"

module ssrac_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input ssrac_pkg::spi_out_t m_data
);

    logic wr_fields_clear;

    assign wr_fields_clear = (m_data.write_index == 2'd0) && (m_data.write_value == 16'd0) &&
                             !m_data.write_crc_ok;

    // Output register holds while stalled.
    `ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // An empty output side never blocks input.
    `ASSERT_IMPLY(a_ready_when_empty, !m_valid, s_ready)

    // Write fields are zero unless a write is reported.
    `ASSERT_IMPLY(a_write_fields_zero, m_valid && !m_data.write_valid, wr_fields_clear)

    // The CRC byte of a write frame is answered with zero.
    `ASSERT_IMPLY(a_write_tx_zero, m_valid && m_data.write_valid, m_data.tx_byte == 8'd0)

    // A stalled input that is not taken stays pending.
    `ASSERT_NEXT(a_in_pending, s_valid && !s_ready, s_valid)

endmodule

bind spi_slave_register_access_crc8_unit ssrac_checker u_checker (.*);
